[src/spq_pkg.sv]
// spq_pkg: shared types and constants of the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue_top
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INS_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REM_EMPTY  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

[src/spq_cell.sv]
// spq_cell: one slot of the shift-register priority queue
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
  input  logic              clk_i,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  spq_pkg::entry_t   new_i,
  input  logic              occupied_i,
  input  logic              left_stay_i,
  input  spq_pkg::entry_t   left_i,
  input  spq_pkg::entry_t   right_i,
  output logic              stay_o,
  output spq_pkg::entry_t   entry_o,
  output spq_pkg::entry_t   entry_d_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // held entry keeps its place when it ranks at or above the new one
  assign stay_o = occupied_i && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (stay_o) begin
        entry_d = entry_q;
      end else if (left_stay_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

[src/sorted_priority_queue_top.sv]
// sorted_priority_queue_top: bounded priority queue built as a chain of cells
// depends on spq_pkg and spq_cell
//
// channel  dir  fields (tdata / tuser, lowest bit first)
// s_axis   in   tdata: item_value[31:0], item_priority[63:32]; tuser: op
// m_axis   out  tdata: head_value[31:0], not_empty[32], occupancy[37:33],
//               is_full[38], status[40:39], zero fill [47:41]
//
// one transaction per cycle while s_axis_tready is high: every cell compares
// its priority with the new item and shifts in parallel, the result lands in
// one output register and is valid in the cycle after the input transaction.
// reset clears the fill count and the output valid; slot contents are not reset.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_value, item_priority
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // head_value, not_empty, occupancy, is_full, status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic              in_fire;
  logic              op;
  spq_pkg::entry_t   new_entry;
  spq_pkg::cell_cmd_t cmd;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              full, empty;
  logic [spq_pkg::STAT_W-1:0] status;

  logic              out_valid_q;
  logic [47:0]       out_data_q, out_data_d;

  spq_pkg::entry_t   entry   [DEPTH];
  spq_pkg::entry_t   entry_d [DEPTH];
  logic              stay    [DEPTH];

  assign s_axis_tready   = !out_valid_q || m_axis_tready;
  assign in_fire         = s_axis_tvalid && s_axis_tready;
  assign op              = s_axis_tuser;
  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.prio  = s_axis_tdata[63:32];

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    cmd     = '0;
    count_d = count_q;
    status  = spq_pkg::STAT_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (full) begin
        status = spq_pkg::STAT_INS_FULL;
      end else begin
        cmd.ins = in_fire;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status = spq_pkg::STAT_REM_EMPTY;
      end else begin
        cmd.rem = in_fire;
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            occ;
    logic            left_stay;
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_stay = 1'b1;
      assign left_e    = new_entry;
    end else begin : g_mid
      assign left_stay = stay[i-1];
      assign left_e    = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .new_i       (new_entry),
      .occupied_i  (occ),
      .left_stay_i (left_stay),
      .left_i      (left_e),
      .right_i     (right_e),
      .stay_o      (stay[i]),
      .entry_o     (entry[i]),
      .entry_d_o   (entry_d[i])
    );
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[31:0]  = (count_d != '0) ? entry_d[0].value : '0;
    out_data_d[32]    = (count_d != '0);
    out_data_d[37:33] = spq_pkg::OCC_W'(count_d);
    out_data_d[38]    = (count_d == CNT_W'(DEPTH));
    out_data_d[40:39] = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[bench/tb_sorted_priority_queue_top.sv]
// tb_sorted_priority_queue_top: self-checking bench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue_top; predicts every result in-bench
// and compares it field by field under random input gaps and output stalls
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;

  localparam int DEPTH = 16;

  // status is the top field so that head_value lands in the lowest bits
  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0]        status;
    logic                              is_full;
    logic [spq_pkg::OCC_W-1:0]         occupancy;
    logic                              not_empty;
    logic signed [spq_pkg::DATA_W-1:0] head_value;
  } queue_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  logic signed [spq_pkg::DATA_W-1:0] held_value [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] held_prio  [DEPTH];
  int                                held_count;
  queue_report_t                     expected_reports [$];
  int                                error_count;
  int                                burst_left;
  bit                                calm;
  int                                hold_cycles;

  sorted_priority_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // sorted queue update and the report that the block should give for it
  function automatic void predict_report(logic op, logic signed [spq_pkg::DATA_W-1:0] value,
                                         logic signed [spq_pkg::DATA_W-1:0] prio);
    queue_report_t r;
    int pos;
    int i;
    r.status = spq_pkg::STAT_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = spq_pkg::STAT_INS_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] >= prio) pos++;
        for (i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = value;
        held_prio[pos]  = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = spq_pkg::STAT_REM_EMPTY;
    end else begin
      for (i = 1; i < held_count; i++) begin
        held_value[i-1] = held_value[i];
        held_prio[i-1]  = held_prio[i];
      end
      held_count--;
    end
    r.head_value = (held_count > 0) ? held_value[0] : '0;
    r.not_empty  = (held_count > 0);
    r.occupancy  = held_count[spq_pkg::OCC_W-1:0];
    r.is_full    = (held_count == DEPTH);
    expected_reports = {expected_reports, r};
  endfunction

  function automatic void check_field(string name, logic [spq_pkg::DATA_W-1:0] want,
                                      logic [spq_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    queue_report_t got;
    queue_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[40:0];
      if (expected_reports.size() == 0) begin
        $error("unexpected transaction: head_value 'h%0h occupancy %0d",
               got.head_value, got.occupancy);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("head_value", want.head_value, got.head_value);
        check_field("not_empty", want.not_empty, got.not_empty);
        check_field("occupancy", want.occupancy, got.occupancy);
        check_field("is_full", want.is_full, got.is_full);
        check_field("status", want.status, got.status);
      end
    end
  end

  // receiver: long hold-off on request, always ready in calm phases, otherwise a stall pattern of its own
  initial begin : drive_ready
    logic [15:0] ready_pattern;
    int          step;
    m_axis_tready = 1'b0;
    ready_pattern = '1;
    step = 0;
    forever begin
      @(negedge clk_i);
      if (step % 64 == 0) ready_pattern = 16'($urandom | $urandom);
      step++;
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ready_pattern[step % 16];
      end
    end
  end

  task automatic send_item(logic op, logic signed [spq_pkg::DATA_W-1:0] value,
                           logic signed [spq_pkg::DATA_W-1:0] prio);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_report(op, value, prio);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic logic [spq_pkg::DATA_W-1:0] pick_word(bit narrow);
    logic [spq_pkg::DATA_W-1:0] w;
    case ($urandom_range(0, 5))
      0, 1:    w = narrow ? spq_pkg::DATA_W'($signed($urandom_range(0, 8)) - 4) : $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7fff_ffff;
          2:       w = 32'h0000_0000;
          default: w = 32'hffff_ffff;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic test_remove_on_empty();
    send_item(spq_pkg::OP_REMOVE, 32'h1234_5678, 32'h7fff_ffff);
    send_item(spq_pkg::OP_REMOVE, 32'h8000_0000, 32'h8000_0000);
  endtask

  // extremes of value and priority, plus ties that must leave in insert order
  task automatic test_order_and_ties();
    send_item(spq_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_item(spq_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_item(spq_pkg::OP_INSERT, 32'd1, 32'd0);
    send_item(spq_pkg::OP_INSERT, 32'd2, 32'd0);
    send_item(spq_pkg::OP_INSERT, 32'd3, 32'd0);
    send_item(spq_pkg::OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    send_item(spq_pkg::OP_INSERT, 32'd0, 32'h7fff_ffff);
    repeat (8) send_item(spq_pkg::OP_REMOVE, $urandom, $urandom);
  endtask

  // receiver holds off and stalls the input while inserts go past the depth, then drain past empty
  task automatic test_backpressure_overflow();
    hold_cycles = 300;
    repeat (DEPTH + 4) send_item(spq_pkg::OP_INSERT, $urandom, pick_word(1'b1));
    repeat (DEPTH + 4) send_item(spq_pkg::OP_REMOVE, $urandom, $urandom);
  endtask

  task automatic test_random_mix(int total);
    int sent;
    int phase_len;
    int insert_pct;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      calm = ($urandom_range(0, 4) == 0);
      repeat (phase_len) begin
        if ($urandom_range(1, 100) <= insert_pct) begin
          send_item(spq_pkg::OP_INSERT, pick_word(1'b0), pick_word(1'b1));
        end else begin
          send_item(spq_pkg::OP_REMOVE, $urandom, $urandom);
        end
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = spq_pkg::OP_INSERT;
    held_count    = 0;
    error_count   = 0;
    burst_left    = 0;
    calm          = 1'b0;
    hold_cycles   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_remove_on_empty();
    test_order_and_ties();
    test_backpressure_overflow();
    test_random_mix(1350);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sorted_priority_queue_top.f]
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
bench/tb_sorted_priority_queue_top.sv
